// ===== rtl/spf_pkg.sv =====
// shared constants and types of the 3x3 sharpen filter
// no dependencies; used by the channel interfaces and the top level
package spf_pkg;

  localparam int unsigned DEF_MAX_WIDTH = 4096;
  localparam int unsigned DEF_MAX_BPP   = 4;

  localparam int unsigned SAMPLE_W   = 8;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned WIDTH_W    = 13;
  localparam int unsigned HEIGHT_W   = 16;
  localparam int unsigned BPP_W      = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PERCENT = 2'd0,
    REG_WIDTH   = 2'd1,
    REG_HEIGHT  = 2'd2,
    REG_BPP     = 2'd3
  } cfg_reg_e;

  localparam logic OP_PUSH  = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [PCT_W-1:0]    RST_PERCENT = 7'd10;
  localparam logic [WIDTH_W-1:0]  RST_WIDTH   = 13'd640;
  localparam logic [HEIGHT_W-1:0] RST_HEIGHT  = 16'd480;
  localparam logic [BPP_W-1:0]    RST_BPP     = 3'd3;

  localparam int unsigned PCT_FULL  = 100;
  localparam int unsigned SAT_VALUE = 255;

endpackage

// ===== rtl/spf_stream_if.sv =====
// valid/ready channel interfaces for sample input and filtered output
// depends on spf_pkg
interface spf_in_if;
  import spf_pkg::*;
  logic                valid;
  logic                ready;
  logic                opcode;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, opcode, sample, input ready);
  modport sink   (input valid, opcode, sample, output ready);
endinterface

interface spf_out_if;
  import spf_pkg::*;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] value;
  logic                last_of_frame;
  modport source (output valid, value, last_of_frame, input ready);
  modport sink   (input valid, value, last_of_frame, output ready);
endinterface

// ===== rtl/sharpen_3x3_percent_filter_unit.sv =====
// 3x3 percent sharpen filter over an interleaved byte stream, line stores in one ram
// depends on spf_pkg and spf_stream_if
// sequence: a push that yields no result is taken without leaving idle; a result on a
//   border byte passes through the read, wait, multiply, numerator and output states, and
//   on an interior byte also through nine reads and the serial divide (skipped when negative)
// throughput: one item at a time; set by up to nine reads through the single ram port
//   and the 15-step serial divider
// reset: counters and handshake clear at once, configuration loads its defaults; datapath and line ram are not cleared
module sharpen_3x3_percent_filter_unit #(
  parameter int unsigned MAX_WIDTH = spf_pkg::DEF_MAX_WIDTH,
  parameter int unsigned MAX_BPP   = spf_pkg::DEF_MAX_BPP
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  spf_in_if.sink                          in_i,
  spf_out_if.source                       out_o,
  input  logic                            cfg_we_i,
  input  logic [spf_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [spf_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import spf_pkg::*;

  localparam int unsigned LINE_BYTES = MAX_WIDTH * MAX_BPP;
  localparam int unsigned COL_W      = $clog2(LINE_BYTES);
  localparam int unsigned RB_W       = $clog2(LINE_BYTES + 1);
  localparam int unsigned PEND_W     = RB_W + 1;
  localparam int unsigned MEM_DEPTH  = 3 * (2 ** COL_W);
  localparam int unsigned SUM_W      = 11;
  localparam int unsigned PROD_W     = SUM_W + PCT_W;
  localparam int unsigned DIV_W      = 15;
  localparam int unsigned DCNT_W     = 4;

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_READ = 3'd1;
  localparam logic [2:0] S_WAIT = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_NUM  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  // configuration
  logic [PCT_W-1:0]    pct_q;
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [BPP_W-1:0]    bpp_q;

  // stream position
  logic [COL_W-1:0]    in_col_q, out_col_q;
  logic [HEIGHT_W-1:0] in_row_q, out_row_q;
  logic [1:0]          in_bank_q, out_bank_q;
  logic [PEND_W-1:0]   pend_q;

  logic [2:0]          state_q;
  logic [3:0]          rd_cnt_q, rd_idx_q;
  logic                rd_vld_q;
  logic                interior_q, last_q;
  logic [SAMPLE_W-1:0] center_q, rdata_q;
  logic [SUM_W-1:0]    sum_q;
  logic [PROD_W-1:0]   prod_q;
  logic [DIV_W-1:0]    div_q;
  logic [7:0]          rem_q;
  logic [DCNT_W-1:0]   dcnt_q;

  logic                out_vld_q, out_last_q;
  logic [SAMPLE_W-1:0] out_val_q;

  logic [SAMPLE_W-1:0] mem_q [MEM_DEPTH];

  // effective geometry, out-of-range registers folded in
  logic [BPP_W-1:0]    bpp_eff;
  logic [RB_W-1:0]     w_eff, rb;
  logic [HEIGHT_W-1:0] h_eff;
  logic [PEND_W-1:0]   delay, pend_inc;
  logic [PCT_W-1:0]    fact;

  always_comb begin
    if (bpp_q == '0) begin
      bpp_eff = BPP_W'(1);
    end else if (bpp_q > BPP_W'(MAX_BPP)) begin
      bpp_eff = BPP_W'(MAX_BPP);
    end else begin
      bpp_eff = bpp_q;
    end
    if (width_q == '0) begin
      w_eff = RB_W'(1);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_eff = RB_W'(MAX_WIDTH);
    end else begin
      w_eff = RB_W'(width_q);
    end
    rb       = RB_W'(w_eff * bpp_eff);
    h_eff    = (height_q == '0) ? HEIGHT_W'(1) : height_q;
    delay    = PEND_W'(rb) + PEND_W'(bpp_eff);
    pend_inc = pend_q + PEND_W'(1);
    fact     = (pct_q >= PCT_W'(PCT_FULL)) ? PCT_W'(1) : PCT_W'(PCT_FULL) - pct_q;
  end

  // transfer decode
  logic in_xfer, push_ok, push_emit, drain_emit, start_emit;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_xfer    = in_i.valid && in_i.ready;
  assign push_ok    = in_xfer && (in_i.opcode == OP_PUSH) && (in_row_q < h_eff);
  assign push_emit  = push_ok && (pend_inc > delay);
  assign drain_emit = in_xfer && (in_i.opcode == OP_DRAIN) && (in_row_q >= h_eff)
                      && (pend_q != '0);
  assign start_emit = push_emit || drain_emit;

  // position of the result about to be produced
  logic in_col_end, out_col_end, out_interior, out_last;
  always_comb begin
    in_col_end   = (PEND_W'(in_col_q) + PEND_W'(1)) >= PEND_W'(rb);
    out_col_end  = (PEND_W'(out_col_q) + PEND_W'(1)) >= PEND_W'(rb);
    out_interior = (out_row_q != '0)
                   && ((17'(out_row_q) + 17'd1) < 17'(h_eff))
                   && (PEND_W'(out_col_q) >= PEND_W'(bpp_eff))
                   && ((PEND_W'(out_col_q) + PEND_W'(bpp_eff)) < PEND_W'(rb));
    out_last     = ((17'(out_row_q) + 17'd1) >= 17'(h_eff)) && out_col_end;
  end

  // read address of window tap rd_cnt_q: centre first, then the eight neighbors
  logic [1:0]       up_bank, dn_bank, rd_bank;
  logic [COL_W-1:0] rd_col;
  always_comb begin
    up_bank = (out_bank_q == 2'd0) ? 2'd2 : out_bank_q - 2'd1;
    dn_bank = (out_bank_q == 2'd2) ? 2'd0 : out_bank_q + 2'd1;
    rd_bank = out_bank_q;
    if (rd_cnt_q inside {4'd1, 4'd2, 4'd3}) begin
      rd_bank = up_bank;
    end else if (rd_cnt_q inside {4'd6, 4'd7, 4'd8}) begin
      rd_bank = dn_bank;
    end
    rd_col = out_col_q;
    if (rd_cnt_q inside {4'd1, 4'd4, 4'd6}) begin
      rd_col = out_col_q - COL_W'(bpp_eff);
    end else if (rd_cnt_q inside {4'd3, 4'd5, 4'd8}) begin
      rd_col = out_col_q + COL_W'(bpp_eff);
    end
  end

  // line ram: one write on a pushed byte, registered reads while fetching the window
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[{in_bank_q, in_col_q}] <= in_i.sample;
    end
    if (state_q == S_READ) begin
      rdata_q <= mem_q[{rd_bank, rd_col}];
    end
  end

  // numerator and one restoring divide step
  logic [DIV_W-1:0] c100, psh;
  logic [DIV_W:0]   num;
  logic [8:0]       dtrial;
  logic             dge;
  always_comb begin
    c100   = DIV_W'(center_q * PCT_FULL);
    psh    = prod_q[PROD_W-1:3];
    num    = {1'b0, c100} - {1'b0, psh};
    dtrial = {rem_q, div_q[DIV_W-1]};
    dge    = dtrial >= {2'b00, fact};
  end

  logic out_take;
  assign out_take = (state_q == S_OUT) && (!out_vld_q || out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pct_q      <= RST_PERCENT;
      width_q    <= RST_WIDTH;
      height_q   <= RST_HEIGHT;
      bpp_q      <= RST_BPP;
      in_col_q   <= '0;
      in_row_q   <= '0;
      in_bank_q  <= '0;
      out_col_q  <= '0;
      out_row_q  <= '0;
      out_bank_q <= '0;
      pend_q     <= '0;
      state_q    <= S_IDLE;
      rd_cnt_q   <= '0;
      rd_idx_q   <= '0;
      rd_vld_q   <= 1'b0;
      interior_q <= 1'b0;
      last_q     <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      rd_vld_q  <= (state_q == S_READ);
      rd_idx_q  <= rd_cnt_q;
      // output register loads on a take, clears once its transfer is done
      out_vld_q <= out_take || (out_vld_q && !out_o.ready);

      if (cfg_we_i) begin
        // configuration write abandons the frame
        case (cfg_reg_e'(cfg_idx_i))
          REG_PERCENT: pct_q    <= cfg_data_i[PCT_W-1:0];
          REG_WIDTH:   width_q  <= cfg_data_i[WIDTH_W-1:0];
          REG_HEIGHT:  height_q <= cfg_data_i[HEIGHT_W-1:0];
          REG_BPP:     bpp_q    <= cfg_data_i[BPP_W-1:0];
          default:     pct_q    <= pct_q;
        endcase
        in_col_q   <= '0;
        in_row_q   <= '0;
        in_bank_q  <= '0;
        out_col_q  <= '0;
        out_row_q  <= '0;
        out_bank_q <= '0;
        pend_q     <= '0;
      end else if (push_ok) begin
        if (in_col_end) begin
          in_col_q  <= '0;
          in_row_q  <= in_row_q + HEIGHT_W'(1);
          in_bank_q <= (in_bank_q == 2'd2) ? 2'd0 : in_bank_q + 2'd1;
        end else begin
          in_col_q <= in_col_q + COL_W'(1);
        end
        pend_q <= pend_inc;
      end else if (out_take) begin
        if (last_q) begin
          // final byte of the frame, next push starts a new one
          in_col_q   <= '0;
          in_row_q   <= '0;
          in_bank_q  <= '0;
          out_col_q  <= '0;
          out_row_q  <= '0;
          out_bank_q <= '0;
          pend_q     <= '0;
        end else begin
          pend_q <= pend_q - PEND_W'(1);
          if (out_col_end) begin
            out_col_q  <= '0;
            out_row_q  <= out_row_q + HEIGHT_W'(1);
            out_bank_q <= dn_bank;
          end else begin
            out_col_q <= out_col_q + COL_W'(1);
          end
        end
      end

      case (state_q)
        S_IDLE: begin
          if (start_emit) begin
            state_q    <= S_READ;
            rd_cnt_q   <= '0;
            interior_q <= out_interior;
            last_q     <= out_last;
          end
        end
        S_READ: begin
          if (!interior_q || rd_cnt_q == 4'd8) begin
            state_q <= S_WAIT;
          end
          rd_cnt_q <= rd_cnt_q + 4'd1;
        end
        S_WAIT: state_q <= S_MUL;
        S_MUL:  state_q <= S_NUM;
        S_NUM: begin
          if (!interior_q || num[DIV_W]) begin
            state_q <= S_OUT;
          end else begin
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          if (dcnt_q == DCNT_W'(DIV_W - 1)) begin
            state_q <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_take) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE) begin
      sum_q <= '0;
    end else if (rd_vld_q) begin
      if (rd_idx_q == 4'd0) begin
        center_q <= rdata_q;
      end else begin
        sum_q <= sum_q + SUM_W'(rdata_q);
      end
    end
    if (state_q == S_MUL) begin
      prod_q <= sum_q * pct_q;
    end
    if (state_q == S_NUM) begin
      rem_q  <= '0;
      dcnt_q <= '0;
      if (!interior_q) begin
        div_q <= DIV_W'(center_q);
      end else if (num[DIV_W]) begin
        div_q <= '0;
      end else begin
        div_q <= num[DIV_W-1:0];
      end
    end
    if (state_q == S_DIV) begin
      rem_q  <= dge ? 8'(dtrial - {2'b00, fact}) : dtrial[7:0];
      div_q  <= {div_q[DIV_W-2:0], dge};
      dcnt_q <= dcnt_q + DCNT_W'(1);
    end
    if (out_take) begin
      out_val_q  <= (div_q > DIV_W'(SAT_VALUE)) ? SAMPLE_W'(SAT_VALUE) : div_q[SAMPLE_W-1:0];
      out_last_q <= last_q;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.value         = out_val_q;
  assign out_o.last_of_frame = out_last_q;

endmodule
